[rtl/occupancy_grid_gradient_fill_macros.svh]
// assertion helpers used by occupancy_grid_gradient_fill.sv
`ifndef OCCUPANCY_GRID_GRADIENT_FILL_MACROS_SVH
`define OCCUPANCY_GRID_GRADIENT_FILL_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define OGF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define OGF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define OGF_ASSERT_IMP(lbl, ante, cons, msg)
`define OGF_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/ogf_pkg.sv]
package ogf_pkg;

  // default map capacity
  localparam int MAX_ROWS_DEF = 256;
  localparam int MAX_COLS_DEF = 256;

  // field widths
  localparam int OPCODE_W   = 2;
  localparam int COORD_W    = 8;
  localparam int PIX_W      = 8;
  localparam int DIM_W      = 9;
  localparam int HB_W       = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // register reset values
  localparam logic [DIM_W-1:0] MAP_WIDTH_RST   = 9'd256;
  localparam logic [DIM_W-1:0] MAP_HEIGHT_RST  = 9'd256;
  localparam logic [HB_W-1:0]  HALF_BLOCK_RST  = 4'd1;
  localparam logic [PIX_W-1:0] GRAY_STEP_RST   = 8'd5;
  localparam logic [PIX_W-1:0] WHITE_LEVEL_RST = 8'd255;
  localparam logic [PIX_W-1:0] BLACK_LEVEL_RST = 8'd0;

  // command codes
  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2
  } opcode_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_WIDTH   = 3'd0,
    CFG_MAP_HEIGHT  = 3'd1,
    CFG_HALF_BLOCK  = 3'd2,
    CFG_GRAY_STEP   = 3'd3,
    CFG_WHITE_LEVEL = 3'd4,
    CFG_BLACK_LEVEL = 3'd5
  } cfg_reg_e;

endpackage

[rtl/ogf_ram.sv]
module ogf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/occupancy_grid_gradient_fill.sv]
// cell write, unused command or fill run with nothing to do: result in the cycle after
//   the request is taken; with each result taken at once a request is taken every cycle
// cell read: the read-wait state loads the result; no request is taken in that state
// fill run: level tests (closing one included), a read and check per scanned cell and
//   per window cell of each matching cell; no request is taken until the result leaves
// reset: registers to reset values, result register empty, map undefined until written
`include "occupancy_grid_gradient_fill_macros.svh"

module occupancy_grid_gradient_fill #(
  parameter int MAX_ROWS = ogf_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = ogf_pkg::MAX_COLS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ogf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ogf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ogf_pkg::OPCODE_W-1:0]    opcode_i,
  input  logic [ogf_pkg::COORD_W-1:0]     row_index_i,
  input  logic [ogf_pkg::COORD_W-1:0]     col_index_i,
  input  logic [ogf_pkg::PIX_W-1:0]       cell_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ogf_pkg::PIX_W-1:0]       read_value_o,
  output logic                            op_done_o
);

  import ogf_pkg::*;

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int RLW   = ($clog2(MAX_ROWS + 1) > DIM_W) ? $clog2(MAX_ROWS + 1) : DIM_W;
  localparam int CLW   = ($clog2(MAX_COLS + 1) > DIM_W) ? $clog2(MAX_COLS + 1) : DIM_W;
  localparam int REW   = RLW + 1;
  localparam int CEW   = CLW + 1;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [RLW-1:0] ROWS_K   = RLW'(MAX_ROWS);
  localparam logic [CLW-1:0] COLS_K   = CLW'(MAX_COLS);
  localparam logic [AW-1:0]  COLS_MUL = AW'(MAX_COLS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDWAIT,
    S_LVL,
    S_CRD,
    S_CCHK,
    S_WRD,
    S_WCHK
  } state_e;

  // configuration registers
  logic [DIM_W-1:0] map_width_q;
  logic [DIM_W-1:0] map_height_q;
  logic [HB_W-1:0]  half_block_q;
  logic [PIX_W-1:0] gray_step_q;
  logic [PIX_W-1:0] white_q;
  logic [PIX_W-1:0] black_q;

  // sequencer registers
  state_e           state_q;
  logic             out_valid_q;
  logic [PIX_W-1:0] out_value_q;
  logic             rd_inside_q;
  logic [PIX_W-1:0] g_q;
  logic [PIX_W-1:0] next_q;
  logic [RW-1:0]    r_q;
  logic [CW-1:0]    c_q;
  logic [RW-1:0]    y_q;
  logic [CW-1:0]    x_q;
  logic [RW-1:0]    r1_q;
  logic [CW-1:0]    c0_q;
  logic [CW-1:0]    c1_q;

  logic [RLW-1:0]   rows_used;
  logic [CLW-1:0]   cols_used;
  logic [HB_W-1:0]  hb_eff;
  logic             in_acc;
  logic             cmd_inside;
  logic [RW-1:0]    cmd_row;
  logic [CW-1:0]    cmd_col;
  logic             run_empty;
  logic [PIX_W:0]   lvl_sum;
  logic             lvl_go;
  logic [RW-1:0]    a_row;
  logic [CW-1:0]    a_col;
  logic [AW-1:0]    mem_addr;
  logic             mem_we;
  logic [PIX_W-1:0] mem_wdata;
  logic [PIX_W-1:0] mem_rdata;
  logic [REW-1:0]   r_ext;
  logic [REW-1:0]   hb_r;
  logic [REW-1:0]   r_hi;
  logic [REW-1:0]   r_lim;
  logic [REW-1:0]   win_r0;
  logic [REW-1:0]   win_r1;
  logic [CEW-1:0]   c_ext;
  logic [CEW-1:0]   hb_c;
  logic [CEW-1:0]   c_hi;
  logic [CEW-1:0]   c_lim;
  logic [CEW-1:0]   win_c0;
  logic [CEW-1:0]   win_c1;
  logic             c_last;
  logic             r_last;
  state_e           adv_state;
  logic [RW-1:0]    adv_r;
  logic [CW-1:0]    adv_c;
  logic [PIX_W-1:0] adv_g;

  // configuration writes, always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= MAP_WIDTH_RST;
      map_height_q <= MAP_HEIGHT_RST;
      half_block_q <= HALF_BLOCK_RST;
      gray_step_q  <= GRAY_STEP_RST;
      white_q      <= WHITE_LEVEL_RST;
      black_q      <= BLACK_LEVEL_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MAP_WIDTH:   map_width_q  <= cfg_data_i;
        CFG_MAP_HEIGHT:  map_height_q <= cfg_data_i;
        CFG_HALF_BLOCK:  half_block_q <= cfg_data_i[HB_W-1:0];
        CFG_GRAY_STEP:   gray_step_q  <= cfg_data_i[PIX_W-1:0];
        CFG_WHITE_LEVEL: white_q      <= cfg_data_i[PIX_W-1:0];
        CFG_BLACK_LEVEL: black_q      <= cfg_data_i[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // map extent in use and effective window half size
  assign rows_used = (RLW'(map_height_q) < ROWS_K) ? RLW'(map_height_q) : ROWS_K;
  assign cols_used = (CLW'(map_width_q) < COLS_K) ? CLW'(map_width_q) : COLS_K;
  assign hb_eff    = (half_block_q == '0) ? HB_W'(1) : half_block_q;

  // request side
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;
  assign cmd_inside = (RLW'(row_index_i) < rows_used) && (CLW'(col_index_i) < cols_used);
  assign cmd_row    = RW'(RLW'(row_index_i));
  assign cmd_col    = CW'(CLW'(col_index_i));
  assign run_empty  = (rows_used == '0) || (cols_used == '0) || (gray_step_q == '0);

  // level test: stop before the next level would reach white
  assign lvl_sum = {1'b0, g_q} + {1'b0, gray_step_q};
  assign lvl_go  = lvl_sum < {1'b0, white_q};

  // shared address unit
  always_comb begin
    unique case (state_q)
      S_IDLE: begin
        a_row = cmd_row;
        a_col = cmd_col;
      end
      S_CRD, S_CCHK, S_LVL, S_RDWAIT: begin
        a_row = r_q;
        a_col = c_q;
      end
      default: begin
        a_row = y_q;
        a_col = x_q;
      end
    endcase
  end

  assign mem_addr = AW'(a_row) * COLS_MUL + AW'(a_col);

  // map writes: command write in idle, paint of a white cell during the fill
  assign mem_we = ((state_q == S_IDLE) && in_acc && (opcode_i == OP_WRITE) && cmd_inside) ||
                  ((state_q == S_WCHK) && (mem_rdata == white_q));
  assign mem_wdata = (state_q == S_IDLE) ? cell_value_i : next_q;

  ogf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_addr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_addr),
    .rdata_o (mem_rdata)
  );

  // window bounds around the current centre, clipped at the map edges
  assign r_ext  = REW'(r_q);
  assign hb_r   = REW'(hb_eff);
  assign r_hi   = r_ext + hb_r;
  assign r_lim  = REW'(rows_used) - REW'(1);
  assign win_r0 = (r_ext >= hb_r) ? (r_ext - hb_r) : '0;
  assign win_r1 = (r_hi < r_lim) ? r_hi : r_lim;
  assign c_ext  = CEW'(c_q);
  assign hb_c   = CEW'(hb_eff);
  assign c_hi   = c_ext + hb_c;
  assign c_lim  = CEW'(cols_used) - CEW'(1);
  assign win_c0 = (c_ext >= hb_c) ? (c_ext - hb_c) : '0;
  assign win_c1 = (c_hi < c_lim) ? c_hi : c_lim;

  // step to the next centre cell, or to the next level after the last one
  assign c_last = CLW'(c_q) == (cols_used - CLW'(1));
  assign r_last = RLW'(r_q) == (rows_used - RLW'(1));

  always_comb begin
    adv_state = S_CRD;
    adv_r     = r_q;
    adv_c     = c_q + CW'(1);
    adv_g     = g_q;
    if (c_last) begin
      adv_c = '0;
      if (r_last) begin
        adv_r     = '0;
        adv_g     = next_q;
        adv_state = S_LVL;
      end else begin
        adv_r = r_q + RW'(1);
      end
    end
  end

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      rd_inside_q <= 1'b0;
      g_q         <= '0;
      next_q      <= '0;
      r_q         <= '0;
      c_q         <= '0;
      y_q         <= '0;
      x_q         <= '0;
      r1_q        <= '0;
      c0_q        <= '0;
      c1_q        <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            unique case (opcode_i)
              OP_READ: begin
                rd_inside_q <= cmd_inside;
                state_q     <= S_RDWAIT;
              end
              OP_RUN: begin
                if (run_empty) begin
                  out_valid_q <= 1'b1;
                  out_value_q <= '0;
                end else begin
                  g_q     <= black_q;
                  state_q <= S_LVL;
                end
              end
              default: begin
                out_valid_q <= 1'b1;
                out_value_q <= '0;
              end
            endcase
          end
        end
        S_RDWAIT: begin
          out_valid_q <= 1'b1;
          out_value_q <= rd_inside_q ? mem_rdata : '0;
          state_q     <= S_IDLE;
        end
        S_LVL: begin
          if (lvl_go) begin
            next_q  <= lvl_sum[PIX_W-1:0];
            r_q     <= '0;
            c_q     <= '0;
            state_q <= S_CRD;
          end else begin
            out_valid_q <= 1'b1;
            out_value_q <= '0;
            state_q     <= S_IDLE;
          end
        end
        S_CRD: begin
          state_q <= S_CCHK;
        end
        S_CCHK: begin
          if (mem_rdata == g_q) begin
            y_q     <= RW'(win_r0);
            x_q     <= CW'(win_c0);
            r1_q    <= RW'(win_r1);
            c0_q    <= CW'(win_c0);
            c1_q    <= CW'(win_c1);
            state_q <= S_WRD;
          end else begin
            r_q     <= adv_r;
            c_q     <= adv_c;
            g_q     <= adv_g;
            state_q <= adv_state;
          end
        end
        S_WRD: begin
          state_q <= S_WCHK;
        end
        S_WCHK: begin
          if (x_q == c1_q) begin
            x_q <= c0_q;
            if (y_q == r1_q) begin
              r_q     <= adv_r;
              c_q     <= adv_c;
              g_q     <= adv_g;
              state_q <= adv_state;
            end else begin
              y_q     <= y_q + RW'(1);
              state_q <= S_WRD;
            end
          end else begin
            x_q     <= x_q + CW'(1);
            state_q <= S_WRD;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_value_q;
  assign op_done_o    = 1'b1;

  // checks on the sequencer
  `OGF_ASSERT_IMP(a_ready_only_idle, in_ready_o, state_q == S_IDLE, "request taken while busy")
  `OGF_ASSERT_NXT(a_read_result, state_q == S_RDWAIT, out_valid_q, "read result not loaded")
  `OGF_ASSERT_NXT(a_write_result, in_acc && (opcode_i == OP_WRITE), out_valid_q, "no write result")
  `OGF_ASSERT_IMP(a_level_rises, (state_q == S_CCHK || state_q == S_WCHK), next_q > g_q, "flat level")
  `OGF_ASSERT_IMP(a_window_bounds, state_q == S_WRD, (y_q <= r1_q) && (x_q <= c1_q), "window overrun")
  `OGF_ASSERT_IMP(a_window_in_map, state_q == S_WRD, RLW'(r1_q) < rows_used, "window past map")

endmodule
